[rtl/rmq_pkg.sv]
// Shared types and constants for the rotation matrix to quaternion converter.
`default_nettype none
package rmq_pkg;

  // Fixed field widths
  localparam int FIELD_W = 18;
  localparam int MAG_W   = 19;   // magnitude of a pair sum or difference
  localparam int Q_BITS  = 18;   // quotient bits resolved by the divider
  localparam int LANES   = 3;

  localparam logic signed [FIELD_W-1:0] SAT_MAX = 18'sd131071;
  localparam logic signed [FIELD_W-1:0] SAT_MIN = -18'sd131072;

  // Which component carries the root
  typedef enum logic [1:0] {
    BR_TRACE,
    BR_X,
    BR_Y,
    BR_Z
  } branch_t;

  // Side data through the root stages
  typedef struct packed {
    branch_t                        branch;
    logic                           bad;
    logic [LANES-1:0]               neg;
    logic [LANES-1:0][MAG_W-1:0]    mag;
  } side_t;

  // Side data through the divide stages
  typedef struct packed {
    branch_t                branch;
    logic                   bad;
    logic [LANES-1:0]       neg;
    logic [LANES-1:0]       ovf;
    logic [FIELD_W-1:0]     own;
  } dmeta_t;

endpackage
`default_nettype wire

[rtl/rotation_matrix_to_quaternion.sv]
// Rotation matrix to quaternion converter, fully pipelined root and divide.
//
//   channel | ports                                  | direction
//   --------+----------------------------------------+----------
//   input   | in_valid, in_stall, in_m00 .. in_m22   | in (stall out)
//   result  | out_valid, out_stall, out_quat_*,      | out (stall in)
//           | out_bad_matrix                         |
//
// One beat per cycle sustained while the result side does not stall. The stages are:
// one setup stage, SQ_W stages of the bit-serial square root (one root bit each),
// one divider overflow check, 18 restoring divide stages shared by three lanes,
// and the output register. Reset clears valid bits only. A stall on the result
// side freezes the whole pipeline; nothing is dropped or repeated.
`default_nettype none
module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [rmq_pkg::FIELD_W-1:0]  in_m00,
  input  wire logic signed [rmq_pkg::FIELD_W-1:0]  in_m01,
  input  wire logic signed [rmq_pkg::FIELD_W-1:0]  in_m02,
  input  wire logic signed [rmq_pkg::FIELD_W-1:0]  in_m10,
  input  wire logic signed [rmq_pkg::FIELD_W-1:0]  in_m11,
  input  wire logic signed [rmq_pkg::FIELD_W-1:0]  in_m12,
  input  wire logic signed [rmq_pkg::FIELD_W-1:0]  in_m20,
  input  wire logic signed [rmq_pkg::FIELD_W-1:0]  in_m21,
  input  wire logic signed [rmq_pkg::FIELD_W-1:0]  in_m22,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [rmq_pkg::FIELD_W-1:0]       out_quat_w,
  output logic signed [rmq_pkg::FIELD_W-1:0]       out_quat_x,
  output logic signed [rmq_pkg::FIELD_W-1:0]       out_quat_y,
  output logic signed [rmq_pkg::FIELD_W-1:0]       out_quat_z,
  output logic                                     out_bad_matrix
);

  localparam int FW     = rmq_pkg::FIELD_W;
  localparam int MW     = rmq_pkg::MAG_W;
  localparam int QB     = rmq_pkg::Q_BITS;
  localparam int NL     = rmq_pkg::LANES;
  localparam int ARG_W  = ((FRAC_BITS > 19) ? FRAC_BITS : 19) + 3;
  localparam int RAD_W0 = ARG_W - 1 + FRAC_BITS;
  localparam int SQ_W   = (RAD_W0 + 1) / 2;
  localparam int RAD_W  = 2 * SQ_W;
  localparam int REM_W  = SQ_W + 2;
  localparam int D_W    = SQ_W + 1;
  localparam int DW     = MW + FRAC_BITS;
  localparam int CW     = ((DW > D_W + QB) ? DW : D_W + QB) + 1;

  // Pipeline advance
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // ---------------------------------------------------------------- setup stage
  logic signed [FW+1:0]    trace;
  logic signed [ARG_W-1:0] arg;
  logic signed [ARG_W-1:0] one_c;
  logic signed [MW-1:0]    n_a, n_b, n_c, s01, s02, s12;
  logic signed [MW-1:0]    num [NL];
  rmq_pkg::side_t          side_nxt;
  logic [RAD_W-1:0]        rad_nxt;

  always_comb begin
    one_c = ARG_W'(1) <<< FRAC_BITS;
    trace = (FW+2)'(in_m00) + (FW+2)'(in_m11) + (FW+2)'(in_m22);
    n_a = MW'(in_m21) - MW'(in_m12);
    n_b = MW'(in_m02) - MW'(in_m20);
    n_c = MW'(in_m10) - MW'(in_m01);
    s01 = MW'(in_m01) + MW'(in_m10);
    s02 = MW'(in_m02) + MW'(in_m20);
    s12 = MW'(in_m12) + MW'(in_m21);
    if (trace > 0) begin
      side_nxt.branch = rmq_pkg::BR_TRACE;
      arg = one_c + ARG_W'(trace);
      num[0] = n_a; num[1] = n_b; num[2] = n_c;
    end else if (in_m00 > in_m11 && in_m00 > in_m22) begin
      side_nxt.branch = rmq_pkg::BR_X;
      arg = one_c + ARG_W'(in_m00) - ARG_W'(in_m11) - ARG_W'(in_m22);
      num[0] = n_a; num[1] = s01; num[2] = s02;
    end else if (in_m11 > in_m22) begin
      side_nxt.branch = rmq_pkg::BR_Y;
      arg = one_c + ARG_W'(in_m11) - ARG_W'(in_m00) - ARG_W'(in_m22);
      num[0] = n_b; num[1] = s01; num[2] = s12;
    end else begin
      side_nxt.branch = rmq_pkg::BR_Z;
      arg = one_c + ARG_W'(in_m22) - ARG_W'(in_m00) - ARG_W'(in_m11);
      num[0] = n_c; num[1] = s02; num[2] = s12;
    end
    side_nxt.bad = arg[ARG_W-1] || (arg == '0);
    for (int l = 0; l < NL; l++) begin
      side_nxt.neg[l] = num[l][MW-1];
      side_nxt.mag[l] = num[l][MW-1] ? MW'(-num[l]) : MW'(num[l]);
    end
    rad_nxt = side_nxt.bad ? '0 : RAD_W'({arg[ARG_W-2:0], {FRAC_BITS{1'b0}}});
  end

  // ---------------------------------------------------------------- square root
  logic                  sq_vld_r  [SQ_W+1];
  rmq_pkg::side_t        sq_side_r [SQ_W+1];
  logic [RAD_W-1:0]      sq_rad_r  [SQ_W+1];
  logic [REM_W-1:0]      sq_rem_r  [SQ_W+1];
  logic [SQ_W-1:0]       sq_root_r [SQ_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r[0] <= 1'b0;
    end else if (en) begin
      sq_vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_side_r[0] <= side_nxt;
      sq_rad_r[0]  <= rad_nxt;
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < SQ_W; k++) begin : g_sqrt
    logic [REM_W+1:0] cat;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] diff;
    logic             ge;

    // One root bit per stage
    always_comb begin
      cat   = {sq_rem_r[k], sq_rad_r[k][RAD_W-1 -: 2]};
      trial = {2'b00, sq_root_r[k], 2'b01};
      ge    = (cat >= trial);
      diff  = cat - trial;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[k+1] <= 1'b0;
      end else if (en) begin
        sq_vld_r[k+1] <= sq_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_side_r[k+1] <= sq_side_r[k];
        sq_rad_r[k+1]  <= sq_rad_r[k] << 2;
        sq_rem_r[k+1]  <= ge ? diff[REM_W-1:0] : cat[REM_W-1:0];
        sq_root_r[k+1] <= {sq_root_r[k][SQ_W-2:0], ge};
      end
    end
  end

  // ---------------------------------------------------------------- divide
  logic                  dv_vld_r  [QB+1];
  rmq_pkg::dmeta_t       dv_meta_r [QB+1];
  logic [CW-1:0]         dv_d_r    [QB+1];
  logic [CW-1:0]         dv_rem_r  [QB+1][NL];
  logic [QB-1:0]         dv_q_r    [QB+1][NL];

  logic [SQ_W-1:0]       root_f;
  logic [CW-1:0]         d_ext;
  logic [CW-1:0]         dend [NL];
  rmq_pkg::dmeta_t       meta_nxt;

  // Overflow check: quotient of 2^18 or more saturates whatever the sign
  always_comb begin
    root_f          = sq_root_r[SQ_W];
    d_ext           = CW'({root_f, 1'b0});
    meta_nxt.branch = sq_side_r[SQ_W].branch;
    meta_nxt.bad    = sq_side_r[SQ_W].bad;
    meta_nxt.neg    = sq_side_r[SQ_W].neg;
    if ((root_f >> 1) > SQ_W'(rmq_pkg::SAT_MAX)) begin
      meta_nxt.own = rmq_pkg::SAT_MAX;
    end else begin
      meta_nxt.own = FW'(root_f >> 1);
    end
    for (int l = 0; l < NL; l++) begin
      dend[l]         = CW'({sq_side_r[SQ_W].mag[l], {FRAC_BITS{1'b0}}});
      meta_nxt.ovf[l] = (dend[l] >= (d_ext << QB));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else if (en) begin
      dv_vld_r[0] <= sq_vld_r[SQ_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_meta_r[0] <= meta_nxt;
      dv_d_r[0]    <= d_ext;
      for (int l = 0; l < NL; l++) begin
        dv_rem_r[0][l] <= dend[l];
        dv_q_r[0][l]   <= '0;
      end
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    logic [CW-1:0] shd;
    assign shd = dv_d_r[j] << (QB - 1 - j);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[j+1] <= 1'b0;
      end else if (en) begin
        dv_vld_r[j+1] <= dv_vld_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_meta_r[j+1] <= dv_meta_r[j];
        dv_d_r[j+1]    <= dv_d_r[j];
      end
    end

    for (genvar l = 0; l < NL; l++) begin : g_lane
      logic ge;
      assign ge = (dv_rem_r[j][l] >= shd);

      // One quotient bit per stage and lane
      always_ff @(posedge clk) begin
        if (en) begin
          dv_rem_r[j+1][l] <= ge ? dv_rem_r[j][l] - shd : dv_rem_r[j][l];
          dv_q_r[j+1][l]   <= {dv_q_r[j][l][QB-2:0], ge};
        end
      end
    end
  end

  // ---------------------------------------------------------------- output
  function automatic logic [FW-1:0] sat_q(input logic ovf, input logic neg,
                                          input logic [QB-1:0] q);
    logic [FW-1:0] v;
    if (ovf) begin
      v = neg ? rmq_pkg::SAT_MIN : rmq_pkg::SAT_MAX;
    end else if (neg) begin
      v = (q > QB'(131072)) ? rmq_pkg::SAT_MIN : FW'(~q + QB'(1));
    end else begin
      v = (q > QB'(131071)) ? rmq_pkg::SAT_MAX : FW'(q);
    end
    return v;
  endfunction

  rmq_pkg::dmeta_t  fm;
  logic [FW-1:0]    lv [NL];
  logic [FW-1:0]    w_nxt, x_nxt, y_nxt, z_nxt;
  rmq_pkg::branch_t out_branch_r;

  // Quotients fill the three slots left by the root component, in order; a bad matrix zeroes all four
  always_comb begin
    fm = dv_meta_r[QB];
    for (int l = 0; l < NL; l++) begin
      lv[l] = sat_q(fm.ovf[l], fm.neg[l], dv_q_r[QB][l]);
    end
    case (fm.branch)
      rmq_pkg::BR_TRACE: begin
        w_nxt = fm.own; x_nxt = lv[0]; y_nxt = lv[1]; z_nxt = lv[2];
      end
      rmq_pkg::BR_X: begin
        w_nxt = lv[0]; x_nxt = fm.own; y_nxt = lv[1]; z_nxt = lv[2];
      end
      rmq_pkg::BR_Y: begin
        w_nxt = lv[0]; x_nxt = lv[1]; y_nxt = fm.own; z_nxt = lv[2];
      end
      rmq_pkg::BR_Z: begin
        w_nxt = lv[0]; x_nxt = lv[1]; y_nxt = lv[2]; z_nxt = fm.own;
      end
      default: begin
        w_nxt = '0; x_nxt = '0; y_nxt = '0; z_nxt = '0;
      end
    endcase
    if (fm.bad) begin
      w_nxt = '0; x_nxt = '0; y_nxt = '0; z_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_vld_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_quat_w     <= w_nxt;
      out_quat_x     <= x_nxt;
      out_quat_y     <= y_nxt;
      out_quat_z     <= z_nxt;
      out_bad_matrix <= fm.bad;
      out_branch_r   <= fm.branch;
    end
  end

  // ---------------------------------------------------------------- checks
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_matrix |->
      out_quat_w == '0 && out_quat_x == '0 && out_quat_y == '0 && out_quat_z == '0)
    else $error("bad matrix beat with non-zero components");

  a_bad_branch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_matrix |-> out_branch_r != rmq_pkg::BR_TRACE)
    else $error("bad matrix flagged on positive trace");

  a_w_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_bad_matrix && out_branch_r == rmq_pkg::BR_TRACE |->
      !out_quat_w[FW-1])
    else $error("root component negative");

endmodule
`default_nettype wire
